// ----- hw/rtl/smpq_pkg.sv -----
// Shared types and constants of the sorted min-priority queue.
package smpq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_W = 32;

   // smallest field shown while the queue is empty
   localparam logic signed [VALUE_W-1:0] EMPTY_SMALLEST = -32'sd1;

   // request kinds
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [2:0] {
      SMPQ_IDLE,
      SMPQ_SCAN,
      SMPQ_PLACE,
      SMPQ_POPRD,
      SMPQ_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start_push;
      logic start_pop;
      logic shift;
      logic put;
      logic pop_min;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic multi;
      logic pos_one;
      logic ge;
   } status_type;

endpackage

// ----- hw/rtl/smpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module smpq_ram #(
   parameter int WIDTH = smpq_pkg::VALUE_W,
   parameter int DEPTH = smpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/smpq_ctrl.sv -----
// Controller state machine of the sorted min-priority queue.
module smpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  smpq_pkg::status_type   status,
   output smpq_pkg::cmd_type      cmd
);
   import smpq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != SMPQ_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SMPQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         SMPQ_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_PUSH) begin
                  cmd.start_push = 1'b1;
                  if (status.full) begin
                     state_in = SMPQ_DONE;
                  end else if (status.empty) begin
                     state_in = SMPQ_PLACE;
                  end else begin
                     state_in = SMPQ_SCAN;
                  end
               end else begin
                  cmd.start_pop = 1'b1;
                  state_in = status.multi ? SMPQ_POPRD : SMPQ_DONE;
               end
            end
         end
         SMPQ_SCAN: begin
            if (status.ge) begin
               cmd.shift = 1'b1;
               if (status.pos_one) begin
                  state_in = SMPQ_PLACE;
               end
            end else begin
               cmd.put  = 1'b1;
               state_in = SMPQ_DONE;
            end
         end
         SMPQ_PLACE: begin
            cmd.put  = 1'b1;
            state_in = SMPQ_DONE;
         end
         SMPQ_POPRD: begin
            cmd.pop_min = 1'b1;
            state_in    = SMPQ_DONE;
         end
         SMPQ_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = SMPQ_IDLE;
            end
         end
         default: begin
            state_in = SMPQ_IDLE;
         end
      endcase
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != SMPQ_IDLE))
      else $error("accepted word did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == SMPQ_DONE))
      else $error("response raised outside done state");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SMPQ_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == SMPQ_DONE))
      else $error("response overwritten while stalled");

endmodule

// ----- hw/rtl/smpq_datapath.sv -----
// Datapath of the sorted min-priority queue: ring of entries, count, head, result.
module smpq_datapath #(
   parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  req_value,
   input  smpq_pkg::cmd_type                    cmd,
   output smpq_pkg::status_type                 status,
   output logic signed [smpq_pkg::VALUE_W-1:0]  rsp_smallest,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full,
   output logic                                 rsp_overflow
);
   import smpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0]   CAP_SUM = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic signed [VALUE_W-1:0]   value_ff, value_in;
   logic signed [VALUE_W-1:0]   min_ff, min_in;
   logic                        ovf_ff, ovf_in;
   logic signed [VALUE_W-1:0]   rsp_smallest_ff, rsp_smallest_in;
   logic                        rsp_is_empty_ff, rsp_is_empty_in;
   logic                        rsp_is_full_ff, rsp_is_full_in;
   logic                        rsp_overflow_ff, rsp_overflow_in;

   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic signed [VALUE_W-1:0]   wr_data, rd_data;
   logic [CW-1:0]               cnt_m1;

   // physical slot of a position counted from the head, wrapping at capacity
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [AW-1:0] rel);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, rel};
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[AW-1:0];
   endfunction

   smpq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_m1 = count_ff - CW'(1);

   always_comb begin
      status.full    = (count_ff == CAP_CNT);
      status.empty   = (count_ff == '0);
      status.multi   = (count_ff > CW'(1));
      status.pos_one = (pos_ff == AW'(1));
      status.ge      = (rd_data >= value_ff);
   end

   always_comb begin
      count_in        = count_ff;
      head_in         = head_ff;
      pos_in          = pos_ff;
      value_in        = value_ff;
      min_in          = min_ff;
      ovf_in          = ovf_ff;
      rsp_smallest_in = rsp_smallest_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      rsp_is_full_in  = rsp_is_full_ff;
      rsp_overflow_in = rsp_overflow_ff;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = value_ff;
      rd_en   = 1'b0;
      rd_addr = '0;

      if (cmd.start_push) begin
         value_in = req_value;
         ovf_in   = status.full;
         if (!status.full) begin
            count_in = count_ff + CW'(1);
            pos_in   = count_ff[AW-1:0];
            // fetch the tail entry to start the scan
            rd_en    = !status.empty;
            rd_addr  = phys(head_ff, cnt_m1[AW-1:0]);
         end
      end

      if (cmd.start_pop) begin
         ovf_in = 1'b0;
         if (!status.empty) begin
            count_in = cnt_m1;
            head_in  = phys(head_ff, AW'(1));
            rd_en    = status.multi;
            rd_addr  = phys(head_ff, AW'(1));
         end
      end

      if (cmd.shift) begin
         // move entry up one slot, fetch the one below it
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, pos_ff);
         wr_data = rd_data;
         pos_in  = pos_ff - AW'(1);
         rd_en   = (pos_ff > AW'(1));
         rd_addr = phys(head_ff, pos_ff - AW'(2));
      end

      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, pos_ff);
         wr_data = value_ff;
         if (pos_ff == '0) begin
            min_in = value_ff;
         end
      end

      if (cmd.pop_min) begin
         min_in = rd_data;
      end

      if (cmd.load_rsp) begin
         rsp_smallest_in = status.empty ? EMPTY_SMALLEST : min_ff;
         rsp_is_empty_in = status.empty;
         rsp_is_full_in  = status.full;
         rsp_overflow_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
      pos_ff          <= pos_in;
      value_ff        <= value_in;
      min_ff          <= min_in;
      ovf_ff          <= ovf_in;
      rsp_smallest_ff <= rsp_smallest_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_is_full_ff  <= rsp_is_full_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_smallest = rsp_smallest_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;
   assign rsp_overflow = rsp_overflow_ff;

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_push && !status.full) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted push did not grow the queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CAP_CNT))
      else $error("entry count above capacity");

endmodule

// ----- hw/rtl/sorted_min_priority_queue.sv -----
// Top level of the sorted min-priority queue: controller, datapath and entry RAM.
//
// Bounded min-priority queue of signed 32-bit values held in ascending order in
// a ring buffer in one RAM (one write and one registered read port). Each request
// word is a push (req_kind 0) or a pop (req_kind 1) and yields exactly one response
// word: the new smallest value (-1 when empty), empty, full and overflow flags.
// A push lands ahead of stored equal values; a push into a full queue is dropped
// and flagged; a pop of an empty queue changes nothing. Pops only advance the ring
// head. A push walks from the tail down, moving one entry per cycle through the
// RAM port until it finds a smaller one. A pop with two or more entries stored
// makes one RAM read that fetches the new head. One word is in work at a time; a
// finished response waits in its output register while the next request word is
// taken. No clearing pass follows reset.
module sorted_min_priority_queue #(
   parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [smpq_pkg::VALUE_W-1:0]  rsp_smallest,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full,
   output logic                                 rsp_overflow
);
   import smpq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: accept, scan/shift, place, pop read, response hand-off
   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // entry storage, count, head pointer and the response register
   smpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_smallest (rsp_smallest),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .rsp_overflow (rsp_overflow)
   );

endmodule
